### sv/counter_priority_task_scheduler_macros.svh
// Assertion macros used by the scheduler checker.
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CPTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CPTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

### sv/cpts_pkg.sv
// Shared types and constants of the counter-priority task scheduler.
`default_nettype none

package cpts_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_STATE = 2'd2;
    localparam logic [1:0] CMD_SCHED = 2'd3;

    localparam logic [2:0] STATE_RUNNING = 3'd0;

    localparam logic [7:0] SLOT0_PRIORITY = 8'd15;
    localparam logic [8:0] SLOT0_COUNTER  = 9'd15;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] task_index;
        logic       slot_present;
        logic [2:0] new_state;
        logic [7:0] new_priority;
        logic [8:0] new_counter;
        logic [1:0] privilege_level;
    } in_t;

    typedef struct packed {
        logic       rescheduled;
        logic [5:0] next_task;
        logic       recomputed;
        logic       starved;
        logic [8:0] current_counter;
    } out_t;

    // One task table entry as held in the memory.
    typedef struct packed {
        logic       used;
        logic [2:0] run_state;
        logic [7:0] priority_val;
        logic [8:0] counter;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

    typedef struct packed {
        logic found;
        logic zero;
    } scan_stat_t;

endpackage

`default_nettype wire

### sv/cpts_task_ram.sv
// Task table memory: one write and one registered read port, reset defaults via valid bits.
`default_nettype none

module cpts_task_ram #(
    parameter int TASK_SLOTS = 64,
    localparam int IDX_W = $clog2(TASK_SLOTS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire cpts_pkg::entry_t     wr_data,
    output logic                      rd_ok,
    output logic [IDX_W-1:0]          rd_idx,
    output cpts_pkg::entry_t          rd_data
);

    cpts_pkg::entry_t        mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]   valid_reg;
    cpts_pkg::entry_t        raw_reg;
    logic                    raw_valid_reg;
    logic                    rd_ok_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    cpts_pkg::entry_t        dflt;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            raw_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            rd_ok_reg <= rd_en;
            if (rd_en)
            begin
                raw_valid_reg <= valid_reg[rd_addr];
                rd_idx_reg    <= rd_addr;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // An entry never written reads as its reset value.
    always_comb
    begin
        dflt = '0;
        if (rd_idx_reg == '0)
        begin
            dflt.used         = 1'b1;
            dflt.run_state    = cpts_pkg::STATE_RUNNING;
            dflt.priority_val = cpts_pkg::SLOT0_PRIORITY;
            dflt.counter      = cpts_pkg::SLOT0_COUNTER;
        end
    end

    assign rd_data = raw_valid_reg ? raw_reg : dflt;
    assign rd_ok   = rd_ok_reg;
    assign rd_idx  = rd_idx_reg;

endmodule

`default_nettype wire

### sv/cpts_scan.sv
// Best-candidate tracker: keeps the running task with the largest counter seen in a pass.
`default_nettype none

module cpts_scan #(
    parameter int TASK_SLOTS = 64,
    localparam int IDX_W = $clog2(TASK_SLOTS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cpts_pkg::scan_ctl_t  ctl,
    input  wire cpts_pkg::entry_t     entry,
    input  wire logic [IDX_W-1:0]     entry_idx,
    output cpts_pkg::scan_stat_t      stat,
    output logic [IDX_W-1:0]          best_idx
);

    logic             found_reg;
    logic [8:0]       best_cnt_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             take;

    // Slots arrive from high index down, so a strict compare keeps the higher index on a tie.
    assign take = ctl.sample && entry.used && (entry.run_state == cpts_pkg::STATE_RUNNING)
                  && (!found_reg || (entry.counter > best_cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_cnt_reg <= entry.counter;
            best_idx_reg <= entry_idx;
        end
    end

    assign stat.found = found_reg;
    assign stat.zero  = found_reg && (best_cnt_reg == '0);
    assign best_idx   = best_idx_reg;

endmodule

`default_nettype wire

### sv/counter_priority_task_scheduler.sv
// Top level of the counter-priority task scheduler: command sequencer around the task table.
//
//  channel   signals              direction  handshake
//  command   start/busy, request  in         beat taken when start && !busy
//  result    done, result         out        beat shown for one cycle on done
//
// One result beat per command, busy from acceptance until done rises.
// A tick without reschedule passes S_TICK_RD, S_FIN_ISSUE and S_FIN_RD before done,
// an in-range state set passes S_SET_RD and the same two, an entry write only those two.
// A decision scans slots TASK_SLOTS-1..1 through the single memory read port;
// a refill pass rewrites the present slots over the same range and adds a rescan;
// the worst case to done is a user tick that refills.
// Reset is asynchronous; the table reads its reset values through per-slot valid bits.
// The receiver takes every result; nothing stalls the output.
`default_nettype none

module counter_priority_task_scheduler #(
    parameter int TASK_SLOTS = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire cpts_pkg::in_t  request,
    output logic                done,
    output cpts_pkg::out_t      result
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
    localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

    typedef enum logic [9:0] {
        S_IDLE        = 10'b00_0000_0001,
        S_TICK_RD     = 10'b00_0000_0010,
        S_SET_RD      = 10'b00_0000_0100,
        S_SCAN        = 10'b00_0000_1000,
        S_SCAN_LAST   = 10'b00_0001_0000,
        S_EVAL        = 10'b00_0010_0000,
        S_REFILL      = 10'b00_0100_0000,
        S_REFILL_LAST = 10'b00_1000_0000,
        S_FIN_ISSUE   = 10'b01_0000_0000,
        S_FIN_RD      = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    cpts_pkg::in_t        req_reg;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     active_reg, active_next;
    logic                 resched_reg, resched_next;
    logic                 recomp_reg, recomp_next;
    logic                 starved_reg, starved_next;
    logic                 done_reg, done_next;
    cpts_pkg::out_t       result_reg, result_next;

    logic                 rd_en, wr_en, rd_ok;
    logic [IDX_W-1:0]     rd_addr, wr_addr, rd_idx;
    cpts_pkg::entry_t     wr_data, rd_data;
    cpts_pkg::scan_ctl_t  scan_ctl;
    cpts_pkg::scan_stat_t scan_stat;
    logic [IDX_W-1:0]     best_idx;

    logic                 accept;
    logic                 in_range;
    logic [IDX_W-1:0]     idx_in;
    logic [8:0]           refill_cnt;

    assign accept   = start && (state_reg == S_IDLE);
    assign in_range = 32'(request.task_index) < TASK_SLOTS;
    assign idx_in   = IDX_W'(request.task_index);
    assign refill_cnt = {1'b0, rd_data.counter[8:1]} + {1'b0, rd_data.priority_val};

    cpts_task_ram #(.TASK_SLOTS(TASK_SLOTS)) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_ok   (rd_ok),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    cpts_scan #(.TASK_SLOTS(TASK_SLOTS)) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .entry     (rd_data),
        .entry_idx (rd_idx),
        .stat      (scan_stat),
        .best_idx  (best_idx)
    );

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        active_next   = active_reg;
        resched_next  = resched_reg;
        recomp_next   = recomp_reg;
        starved_next  = starved_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg;
        wr_en         = 1'b0;
        wr_addr       = rd_idx;
        wr_data       = rd_data;
        scan_ctl.clear  = 1'b0;
        scan_ctl.sample = rd_ok && ((state_reg == S_SCAN) || (state_reg == S_SCAN_LAST));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    resched_next = 1'b0;
                    recomp_next  = 1'b0;
                    starved_next = 1'b0;
                    case (request.command)
                        cpts_pkg::CMD_TICK:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = active_reg;
                            state_next = S_TICK_RD;
                        end
                        cpts_pkg::CMD_WRITE:
                        begin
                            if (in_range)
                            begin
                                wr_en                = 1'b1;
                                wr_addr              = idx_in;
                                wr_data.used         = request.slot_present;
                                wr_data.run_state    = request.new_state;
                                wr_data.priority_val = request.new_priority;
                                wr_data.counter      = request.new_counter;
                            end
                            state_next = S_FIN_ISSUE;
                        end
                        cpts_pkg::CMD_STATE:
                        begin
                            if (in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = idx_in;
                                state_next = S_SET_RD;
                            end
                            else
                            begin
                                state_next = S_FIN_ISSUE;
                            end
                        end
                        default:
                        begin
                            resched_next   = 1'b1;
                            ptr_next       = LAST_IDX;
                            scan_ctl.clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                    endcase
                end
            end
            S_TICK_RD:
            begin
                // Decrement the current counter, clamping at zero.
                wr_en           = 1'b1;
                wr_addr         = active_reg;
                wr_data.counter = (rd_data.counter > 9'd1) ? (rd_data.counter - 9'd1) : '0;
                if ((rd_data.counter <= 9'd1) && (req_reg.privilege_level != '0))
                begin
                    resched_next   = 1'b1;
                    ptr_next       = LAST_IDX;
                    scan_ctl.clear = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN_ISSUE;
                end
            end
            S_SET_RD:
            begin
                wr_en             = 1'b1;
                wr_data.run_state = req_reg.new_state;
                state_next        = S_FIN_ISSUE;
            end
            S_SCAN:
            begin
                rd_en = 1'b1;
                if (ptr_reg == ONE_IDX)
                begin
                    state_next = S_SCAN_LAST;
                end
                else
                begin
                    ptr_next = ptr_reg - ONE_IDX;
                end
            end
            S_SCAN_LAST:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (scan_stat.zero && !recomp_reg)
                begin
                    recomp_next = 1'b1;
                    ptr_next    = LAST_IDX;
                    state_next  = S_REFILL;
                end
                else
                begin
                    starved_next = scan_stat.zero;
                    active_next  = scan_stat.found ? best_idx : '0;
                    state_next   = S_FIN_ISSUE;
                end
            end
            S_REFILL:
            begin
                rd_en = 1'b1;
                wr_en = rd_ok && rd_data.used;
                wr_data.counter = refill_cnt;
                if (ptr_reg == ONE_IDX)
                begin
                    state_next = S_REFILL_LAST;
                end
                else
                begin
                    ptr_next = ptr_reg - ONE_IDX;
                end
            end
            S_REFILL_LAST:
            begin
                wr_en           = rd_ok && rd_data.used;
                wr_data.counter = refill_cnt;
                ptr_next        = LAST_IDX;
                scan_ctl.clear  = 1'b1;
                state_next      = S_SCAN;
            end
            S_FIN_ISSUE:
            begin
                rd_en      = 1'b1;
                rd_addr    = active_reg;
                state_next = S_FIN_RD;
            end
            S_FIN_RD:
            begin
                done_next                   = 1'b1;
                result_next.rescheduled     = resched_reg;
                result_next.next_task       = 6'(active_reg);
                result_next.recomputed      = recomp_reg;
                result_next.starved         = starved_reg;
                result_next.current_counter = rd_data.counter;
                state_next                  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ptr_reg     <= '0;
            active_reg  <= '0;
            resched_reg <= 1'b0;
            recomp_reg  <= 1'b0;
            starved_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            active_reg  <= active_next;
            resched_reg <= resched_next;
            recomp_reg  <= recomp_next;
            starved_reg <= starved_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### sv/cpts_checker.sv
// Port-level checker for the scheduler and its bind to the top level.
`default_nettype none

`include "counter_priority_task_scheduler_macros.svh"

module cpts_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire cpts_pkg::in_t  request,
    input wire logic           done,
    input wire cpts_pkg::out_t result
);

    logic in_beat;

    assign in_beat = start && !busy;

    // A result beat only closes a command that was in flight.
    `CPTS_ASSERT_SAME(a_done_after_busy, done, $past(busy))
    // An accepted command holds the block busy in the next cycle.
    `CPTS_ASSERT_NEXT(a_accept_busy, in_beat, busy)
    // Refill and starvation flags belong to decisions only.
    `CPTS_ASSERT_SAME(a_flags_need_decision, done && !result.rescheduled,
                      !result.recomputed && !result.starved)
    // Starvation is only seen after a refill, and leaves the chosen counter at zero.
    `CPTS_ASSERT_SAME(a_starved_refilled, done && result.starved,
                      result.recomputed && (result.current_counter == 9'd0))

endmodule

bind counter_priority_task_scheduler cpts_checker u_cpts_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the counter-priority task scheduler.
`timescale 1ns / 1ps

module tb_top;

    typedef cpts_pkg::in_t  in_t;
    typedef cpts_pkg::out_t out_t;

    localparam logic [1:0] CMD_TICK  = cpts_pkg::CMD_TICK;
    localparam logic [1:0] CMD_WRITE = cpts_pkg::CMD_WRITE;
    localparam logic [1:0] CMD_STATE = cpts_pkg::CMD_STATE;
    localparam logic [1:0] CMD_SCHED = cpts_pkg::CMD_SCHED;

    localparam logic [2:0] STATE_RUNNING  = cpts_pkg::STATE_RUNNING;
    localparam logic [7:0] SLOT0_PRIORITY = cpts_pkg::SLOT0_PRIORITY;
    localparam logic [8:0] SLOT0_COUNTER  = cpts_pkg::SLOT0_COUNTER;

    localparam int TASK_SLOTS  = 64;
    localparam int END_WAIT    = 3 * TASK_SLOTS + 64;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 200;
    localparam int MAX_REPORTS = 10;

    localparam logic [2:0] ST_INTERRUPTIBLE   = 3'd1;
    localparam logic [2:0] ST_UNINTERRUPTIBLE = 3'd2;
    localparam logic [2:0] ST_ZOMBIE          = 3'd3;
    localparam logic [2:0] ST_STOPPED         = 3'd4;
    localparam logic [2:0] ST_UNDEF5          = 3'd5;
    localparam logic [2:0] ST_UNDEF7          = 3'd7;

    localparam logic [1:0] PRIV_KERNEL = 2'd0;
    localparam logic [1:0] PRIV_RING1  = 2'd1;
    localparam logic [1:0] PRIV_RING2  = 2'd2;
    localparam logic [1:0] PRIV_USER   = 2'd3;

    typedef struct {
        in_t         req;
        int unsigned idle_pct;
    } queued_cmd_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  request = '0;
    logic busy;
    logic done;
    out_t result;

    queued_cmd_t cmd_queue[$];
    out_t        sched_outcomes[$];

    // Shadow task table
    logic       tbl_used  [TASK_SLOTS];
    logic [2:0] tbl_state [TASK_SLOTS];
    logic [7:0] tbl_prio  [TASK_SLOTS];
    logic [8:0] tbl_cnt   [TASK_SLOTS];
    logic [5:0] cur_task;

    logic took_beat = 1'b0;
    int   fail_count = 0;
    int   stall_cycles = 0;

    counter_priority_task_scheduler #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #2 clk = ~clk;

    function automatic logic [5:0] best_slot(output int best_cnt);
        int         c;
        logic [5:0] pick;
        c = -1;
        pick = '0;
        for (int i = TASK_SLOTS - 1; i >= 1; i--)
        begin
            if (tbl_used[i] && tbl_state[i] == STATE_RUNNING && int'(tbl_cnt[i]) > c)
            begin
                c = int'(tbl_cnt[i]);
                pick = i[5:0];
            end
        end
        best_cnt = c;
        return pick;
    endfunction

    function automatic void pick_next_task(output logic refilled, output logic stuck);
        int         c;
        logic [5:0] pick;
        refilled = 1'b0;
        stuck = 1'b0;
        pick = best_slot(c);
        // All running counters spent: refill every present slot but 0, scan once more
        if (c == 0)
        begin
            for (int i = TASK_SLOTS - 1; i >= 1; i--)
            begin
                if (tbl_used[i])
                    tbl_cnt[i] = (tbl_cnt[i] >> 1) + {1'b0, tbl_prio[i]};
            end
            refilled = 1'b1;
            pick = best_slot(c);
            if (c == 0)
                stuck = 1'b1;
        end
        cur_task = pick;
    endfunction

    function automatic out_t apply_to_table(in_t cmd);
        out_t o;
        o = '0;
        case (cmd.command)
            CMD_TICK:
            begin
                if (tbl_cnt[cur_task] > 9'd1)
                    tbl_cnt[cur_task] = tbl_cnt[cur_task] - 9'd1;
                else
                begin
                    tbl_cnt[cur_task] = '0;
                    if (cmd.privilege_level != PRIV_KERNEL)
                    begin
                        o.rescheduled = 1'b1;
                        pick_next_task(o.recomputed, o.starved);
                    end
                end
            end
            CMD_WRITE:
            begin
                tbl_used[cmd.task_index]  = cmd.slot_present;
                tbl_state[cmd.task_index] = cmd.new_state;
                tbl_prio[cmd.task_index]  = cmd.new_priority;
                tbl_cnt[cmd.task_index]   = cmd.new_counter;
            end
            CMD_STATE:
                tbl_state[cmd.task_index] = cmd.new_state;
            default:
            begin
                o.rescheduled = 1'b1;
                pick_next_task(o.recomputed, o.starved);
            end
        endcase
        o.next_task = cur_task;
        o.current_counter = tbl_cnt[cur_task];
        return o;
    endfunction

    function automatic in_t mk(logic [1:0] cmd, logic [5:0] idx, logic present,
                               logic [2:0] state, logic [7:0] prio, logic [8:0] cnt,
                               logic [1:0] priv);
        in_t r;
        r.command         = cmd;
        r.task_index      = idx;
        r.slot_present    = present;
        r.new_state       = state;
        r.new_priority    = prio;
        r.new_counter     = cnt;
        r.privilege_level = priv;
        return r;
    endfunction

    // Bias toward a few busy slots with short slices so ticks keep forcing decisions
    function automatic in_t random_command();
        in_t         r;
        int unsigned sel;
        r = in_t'($urandom);
        if ($urandom_range(99) < 10)
            return r;
        sel = $urandom_range(99);
        r.command = (sel < 45) ? CMD_TICK : (sel < 70) ? CMD_WRITE :
                    (sel < 85) ? CMD_STATE : CMD_SCHED;
        r.task_index = ($urandom_range(99) < 80) ? 6'($urandom_range(7))
                                                 : 6'($urandom_range(63));
        r.slot_present = ($urandom_range(99) < 85);
        r.new_state = ($urandom_range(99) < 65) ? STATE_RUNNING : 3'($urandom_range(1, 7));
        sel = $urandom_range(99);
        r.new_priority = (sel < 15) ? 8'd0 : (sel < 95) ? 8'($urandom_range(1, 6))
                                                          : 8'($urandom_range(255));
        r.new_counter = ($urandom_range(99) < 85) ? 9'($urandom_range(6))
                                                   : 9'($urandom_range(511));
        r.privilege_level = 2'($urandom_range(3));
        return r;
    endfunction

    task automatic add_cmd(in_t req, int unsigned idle_pct);
        queued_cmd_t q;
        q.req = req;
        q.idle_pct = idle_pct;
        cmd_queue.push_back(q);
    endtask

    // Driver: change inputs on the falling edge, hold a beat until it is taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || took_beat))
        begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= cmd_queue[0].idle_pct)
            begin
                request <= cmd_queue[0].req;
                start <= 1'b1;
                void'(cmd_queue.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check result beats, predict on accepted command beats
    always @(posedge clk)
    begin
        out_t want;
        logic active;
        if (!rst_n)
            took_beat <= 1'b0;
        else
        begin
            active = 1'b0;
            if (done)
            begin
                active = 1'b1;
                if (sched_outcomes.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected result beat: %p", result);
                    fail_count++;
                end
                else
                begin
                    want = sched_outcomes.pop_front();
                    if (result.rescheduled !== want.rescheduled
                        || result.next_task !== want.next_task
                        || result.recomputed !== want.recomputed
                        || result.starved !== want.starved
                        || result.current_counter !== want.current_counter)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display("result mismatch: expected %p, got %p", want, result);
                        fail_count++;
                    end
                end
            end
            took_beat <= start && !busy;
            if (start && !busy)
            begin
                active = 1'b1;
                sched_outcomes.push_back(apply_to_table(request));
            end
            stall_cycles = active ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            tbl_used[i]  = (i == 0);
            tbl_state[i] = STATE_RUNNING;
            tbl_prio[i]  = (i == 0) ? SLOT0_PRIORITY : 8'd0;
            tbl_cnt[i]   = (i == 0) ? SLOT0_COUNTER : 9'd0;
        end
        cur_task = '0;

        // Directed: only slot 0 exists, then field extremes, refill and starvation
        add_cmd(mk(CMD_SCHED, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_TICK, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_WRITE, 6'd63, 1'b1, STATE_RUNNING, 8'd255, 9'd511, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_WRITE, 6'd1, 1'b1, STATE_RUNNING, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_SCHED, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_TICK, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_USER), 9);
        add_cmd(mk(CMD_STATE, 6'd63, 1'b0, ST_UNDEF7, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_STATE, 6'd63, 1'b0, ST_STOPPED, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_SCHED, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_TICK, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_RING1), 9);
        add_cmd(mk(CMD_TICK, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_WRITE, 6'd2, 1'b1, STATE_RUNNING, 8'd1, 9'd1, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_TICK, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_RING2), 9);
        add_cmd(mk(CMD_TICK, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_RING2), 9);
        add_cmd(mk(CMD_WRITE, 6'd0, 1'b0, ST_UNDEF5, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_STATE, 6'd2, 1'b0, ST_INTERRUPTIBLE, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_STATE, 6'd1, 1'b0, ST_UNINTERRUPTIBLE, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_SCHED, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_TICK, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_USER), 9);
        add_cmd(mk(CMD_WRITE, 6'd5, 1'b0, STATE_RUNNING, 8'd9, 9'd100, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_WRITE, 6'd62, 1'b1, STATE_RUNNING, 8'd128, 9'd256, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_WRITE, 6'd61, 1'b1, STATE_RUNNING, 8'd128, 9'd256, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_SCHED, 6'd0, 1'b0, STATE_RUNNING, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_STATE, 6'd62, 1'b0, ST_ZOMBIE, 8'd0, 9'd0, PRIV_KERNEL), 9);
        add_cmd(mk(CMD_WRITE, 6'd0, 1'b1, STATE_RUNNING, 8'd15, 9'd15, PRIV_KERNEL), 9);

        for (int i = 0; i < PHASE_ITEMS; i++)
            add_cmd(random_command(), 9);
        for (int i = 0; i < PHASE_ITEMS; i++)
            add_cmd(random_command(), 54);
        for (int i = 0; i < PHASE_ITEMS; i++)
            add_cmd(random_command(), 0);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || sched_outcomes.size() != 0)
            @(negedge clk);
        repeat (END_WAIT) @(negedge clk);

        if (fail_count == 0 && sched_outcomes.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
